// ----- design/assert_macros.svh -----
// Assertion macros used by the predictor RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- design/tbdp_pkg.sv -----
// Package for the tournament branch direction predictor.
// Table sizes, counter constants, opcodes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package tbdp_pkg;

    localparam int LOCAL_INDEX_BITS    = 10;
    localparam int LOCAL_HISTORY_BITS  = 10;
    localparam int GLOBAL_HISTORY_BITS = 12;

    localparam int LIDX_DEPTH  = 1 << LOCAL_INDEX_BITS;
    localparam int LHIST_DEPTH = 1 << LOCAL_HISTORY_BITS;
    localparam int GHIST_DEPTH = 1 << GLOBAL_HISTORY_BITS;

    // clear sweep covers the deepest table
    localparam int CLR_A    = (LOCAL_INDEX_BITS > LOCAL_HISTORY_BITS) ?
                              LOCAL_INDEX_BITS : LOCAL_HISTORY_BITS;
    localparam int CLR_BITS = (CLR_A > GLOBAL_HISTORY_BITS) ? CLR_A : GLOBAL_HISTORY_BITS;

    localparam logic [2:0] LCTR_MAX = 3'd7;
    localparam logic [2:0] LCTR_RST = 3'd2;
    localparam logic [1:0] GCTR_MAX = 2'd3;
    localparam logic [1:0] GCTR_RST = 2'd1;
    localparam logic [1:0] CHSR_RST = 2'd1;

    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CNT,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;    // latch the input word
        logic clear_en;   // write reset values, advance sweep counter
        logic upd_write;  // commit an update
        logic pred_load;  // load a prediction into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;   // sweep counter at its final entry
        logic is_update;  // captured word is an update
        logic out_free;   // output register can take a word this cycle
    } t_dp_status;

endpackage

`default_nettype wire

// ----- design/tournament_branch_direction_predictor.sv -----
// Tournament branch direction predictor (local / global with chooser).
// Input channel: one word per predict or update (i_func selects), valid/stall.
// Output channel: one word per predict, none per update, valid/stall.
// After reset the input is stalled while a sweep writes the reset values
// into every table (one entry of each table per cycle, deepest table sets
// the length).
// Each word then passes through these steps before the next can be taken:
// accept, local history read, counter read addressed by that history,
// execute. The two dependent table reads in series set its length.
// A prediction is loaded into the output register in its execute step.
// The output register holds a prediction while the receiver stalls; a
// following update proceeds normally, a following predict waits in its
// execute step until the output register is free.
// Unconditional predicts return taken with the other fields clear and do
// not touch the tables or the remembered guesses.
// Depends on tbdp_pkg, tbdp_ctrl and tbdp_dp.
`default_nettype none

module tournament_branch_direction_predictor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_func,
    input  wire  [31:0] i_branch_address,
    input  wire         i_is_conditional,
    input  wire         i_taken,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_predicted_taken,
    output logic        o_local_guess,
    output logic        o_global_guess,
    output logic        o_used_local
);

    tbdp_pkg::t_dp_cmd    cmd;
    tbdp_pkg::t_dp_status status;

    tbdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tbdp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_func            (i_func),
        .i_branch_address  (i_branch_address),
        .i_is_conditional  (i_is_conditional),
        .i_taken           (i_taken),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_predicted_taken (o_predicted_taken),
        .o_local_guess     (o_local_guess),
        .o_global_guess    (o_global_guess),
        .o_used_local      (o_used_local)
    );

endmodule

`default_nettype wire

// ----- design/tbdp_ctrl.sv -----
// Controller of the tournament branch direction predictor.
// Sequences the clear sweep and the read / read / execute steps of a word.
// Depends on tbdp_pkg.
`default_nettype none

module tbdp_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  tbdp_pkg::t_dp_status i_status,
    output tbdp_pkg::t_dp_cmd    o_cmd
);

    tbdp_pkg::t_state r_state;
    tbdp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbdp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tbdp_pkg::ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = tbdp_pkg::ST_IDLE;
                end
            end
            tbdp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = tbdp_pkg::ST_HIST;
                end
            end
            tbdp_pkg::ST_HIST: begin
                n_state = tbdp_pkg::ST_CNT;
            end
            tbdp_pkg::ST_CNT: begin
                n_state = tbdp_pkg::ST_EXEC;
            end
            tbdp_pkg::ST_EXEC: begin
                if (i_status.is_update) begin
                    o_cmd.upd_write = 1'b1;
                    n_state         = tbdp_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.pred_load = 1'b1;
                    n_state         = tbdp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbdp_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/tbdp_dp.sv -----
// Datapath of the tournament branch direction predictor.
// Holds the four tables, global history, remembered guesses and output register.
// Depends on tbdp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tbdp_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  tbdp_pkg::t_dp_cmd    i_cmd,
    output tbdp_pkg::t_dp_status o_status,
    input  wire                  i_func,
    input  wire  [31:0]          i_branch_address,
    input  wire                  i_is_conditional,
    input  wire                  i_taken,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_predicted_taken,
    output logic                 o_local_guess,
    output logic                 o_global_guess,
    output logic                 o_used_local
);

    localparam int LIB = tbdp_pkg::LOCAL_INDEX_BITS;
    localparam int LHB = tbdp_pkg::LOCAL_HISTORY_BITS;
    localparam int GHB = tbdp_pkg::GLOBAL_HISTORY_BITS;
    localparam int CLB = tbdp_pkg::CLR_BITS;

    logic [LHB-1:0] r_lht [tbdp_pkg::LIDX_DEPTH];
    logic [2:0]     r_lct [tbdp_pkg::LHIST_DEPTH];
    logic [1:0]     r_gct [tbdp_pkg::GHIST_DEPTH];
    logic [1:0]     r_cht [tbdp_pkg::GHIST_DEPTH];

    logic [CLB-1:0] r_clr_cnt;
    logic [GHB-1:0] r_ghist;
    logic           r_last_lg;
    logic           r_last_gg;

    // captured word
    logic           r_func;
    logic [LIB-1:0] r_lidx;
    logic           r_cond;
    logic           r_taken;

    // registered table reads
    logic [LHB-1:0] r_lh_q;
    logic [2:0]     r_lc_q;
    logic [1:0]     r_gc_q;
    logic [1:0]     r_ch_q;

    logic           r_out_valid;
    logic           r_out_pred;
    logic           r_out_lg;
    logic           r_out_gg;
    logic           r_out_ul;

    logic [2:0]     n_lc;
    logic [1:0]     n_gc;
    logic [1:0]     n_ch;
    logic           local_right;
    logic           chooser_move;
    logic           out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.clr_last  = &r_clr_cnt;
    assign o_status.is_update = (r_func == tbdp_pkg::FUNC_UPDATE);
    assign o_status.out_free  = out_free;

    // saturating moves toward the outcome; the chooser moves toward local when the local guess was right
    always_comb begin
        if (r_taken) begin
            n_lc = (r_lc_q == tbdp_pkg::LCTR_MAX) ? r_lc_q : r_lc_q + 3'd1;
            n_gc = (r_gc_q == tbdp_pkg::GCTR_MAX) ? r_gc_q : r_gc_q + 2'd1;
        end else begin
            n_lc = (r_lc_q == 3'd0) ? r_lc_q : r_lc_q - 3'd1;
            n_gc = (r_gc_q == 2'd0) ? r_gc_q : r_gc_q - 2'd1;
        end
        local_right  = (r_last_lg == r_taken);
        chooser_move = (r_last_lg != r_last_gg);
        if (local_right) begin
            n_ch = (r_ch_q == tbdp_pkg::GCTR_MAX) ? r_ch_q : r_ch_q + 2'd1;
        end else begin
            n_ch = (r_ch_q == 2'd0) ? r_ch_q : r_ch_q - 2'd1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_ghist     <= '0;
            r_last_lg   <= 1'b0;
            r_last_gg   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.upd_write) begin
                r_ghist <= {r_ghist[GHB-2:0], r_taken};
            end
            if (i_cmd.pred_load && r_cond) begin
                r_last_lg <= r_lc_q[2];
                r_last_gg <= r_gc_q[1];
            end
            if (i_cmd.pred_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured word and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_lidx  <= i_branch_address[LIB-1:0];
            r_cond  <= i_is_conditional;
            r_taken <= i_taken;
        end
        if (i_cmd.pred_load) begin
            if (r_cond) begin
                r_out_pred <= r_ch_q[1] ? r_lc_q[2] : r_gc_q[1];
                r_out_lg   <= r_lc_q[2];
                r_out_gg   <= r_gc_q[1];
                r_out_ul   <= r_ch_q[1];
            end else begin
                r_out_pred <= 1'b1;
                r_out_lg   <= 1'b0;
                r_out_gg   <= 1'b0;
                r_out_ul   <= 1'b0;
            end
        end
    end

    // local history table
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_lht[r_clr_cnt[LIB-1:0]] <= '0;
        end else if (i_cmd.upd_write) begin
            r_lht[r_lidx] <= {r_lh_q[LHB-2:0], r_taken};
        end
        r_lh_q <= r_lht[r_lidx];
    end

    // local counter table, indexed by the local history
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_lct[r_clr_cnt[LHB-1:0]] <= tbdp_pkg::LCTR_RST;
        end else if (i_cmd.upd_write) begin
            r_lct[r_lh_q] <= n_lc;
        end
        r_lc_q <= r_lct[r_lh_q];
    end

    // global counter table
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_gct[r_clr_cnt[GHB-1:0]] <= tbdp_pkg::GCTR_RST;
        end else if (i_cmd.upd_write) begin
            r_gct[r_ghist] <= n_gc;
        end
        r_gc_q <= r_gct[r_ghist];
    end

    // chooser table; moves only when the remembered guesses disagreed
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_cht[r_clr_cnt[GHB-1:0]] <= tbdp_pkg::CHSR_RST;
        end else if (i_cmd.upd_write && chooser_move) begin
            r_cht[r_ghist] <= n_ch;
        end
        r_ch_q <= r_cht[r_ghist];
    end

    assign o_out_valid       = r_out_valid;
    assign o_predicted_taken = r_out_pred;
    assign o_local_guess     = r_out_lg;
    assign o_global_guess    = r_out_gg;
    assign o_used_local      = r_out_ul;

    `CHK_SAME(a_no_overwrite, i_clk, i_rst_n, i_cmd.pred_load, out_free)
    `CHK_SAME(a_rose_from_load, i_clk, i_rst_n, $rose(r_out_valid), $past(i_cmd.pred_load))
    `CHK_SAME(a_clear_excl, i_clk, i_rst_n, i_cmd.upd_write || i_cmd.pred_load, !i_cmd.clear_en)
    `CHK_NEXT(a_ghist_shift, i_clk, i_rst_n, i_cmd.upd_write, r_ghist[0] == $past(r_taken))

endmodule

`default_nettype wire
